[rtl/assert_macros.svh]
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/gasp_pkg.sv]
`default_nettype none
package gasp_pkg;

  localparam int HW  = 8;   // heuristic width
  localparam int DW  = 7;   // row or column distance width
  localparam int SQW = 16;  // squarer result width

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_MARK  = 2'd1;
  localparam logic [1:0] ACT_RUN   = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  localparam logic [2:0] ST_ACK          = 3'd0;
  localparam logic [2:0] ST_GOAL         = 3'd1;
  localparam logic [2:0] ST_NOPATH       = 3'd2;
  localparam logic [2:0] ST_LIMIT_NOPATH = 3'd3;
  localparam logic [2:0] ST_LIMIT_PATH   = 3'd4;

  localparam logic [2:0] CFG_HEIGHT = 3'd0;
  localparam logic [2:0] CFG_WIDTH  = 3'd1;
  localparam logic [2:0] CFG_SROW   = 3'd2;
  localparam logic [2:0] CFG_SCOL   = 3'd3;
  localparam logic [2:0] CFG_GROW   = 3'd4;
  localparam logic [2:0] CFG_GCOL   = 3'd5;
  localparam logic [2:0] CFG_LIMIT  = 3'd6;

  localparam int STEP_DR [4] = '{1, -1, 0, 0};
  localparam int STEP_DC [4] = '{0, 0, 1, -1};

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_RSTART, S_HSTART, S_LIMIT, S_SCAN, S_PICK, S_NB, S_NBW, S_NBH
  } state_t;

  typedef enum logic [2:0] {H_IDLE, H_DC, H_ROOT, H_FIX} heur_state_t;

  typedef struct packed {
    logic          go;
    logic [DW-1:0] dr;
    logic [DW-1:0] dc;
  } heur_req_t;

  typedef struct packed {
    logic          done;
    logic [HW-1:0] h;
  } heur_rsp_t;

endpackage
`default_nettype wire

[rtl/gasp_heur.sv]
`default_nettype none
module gasp_heur (
  input  logic                clk,
  input  logic                rst,
  input  gasp_pkg::heur_req_t req,
  output gasp_pkg::heur_rsp_t rsp
);
  import gasp_pkg::*;

  localparam int BW = $clog2(HW);

  heur_state_t   state, state_next;
  logic [DW-1:0] dc_l, dc_l_next;
  logic [SQW-1:0] acc, acc_next;
  logic [HW-1:0] root, root_next;
  logic [BW-1:0] bitn, bitn_next;
  logic [HW-1:0] sq_in, trial;
  logic [SQW-1:0] sq;
  heur_rsp_t     rsp_next;

  // one shared squarer
  assign sq    = SQW'(sq_in) * SQW'(sq_in);
  assign trial = root | (HW'(1) << bitn);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= H_IDLE;
      rsp.done <= 1'b0;
    end else begin
      state    <= state_next;
      rsp.done <= rsp_next.done;
    end
    rsp.h <= rsp_next.h;
    dc_l  <= dc_l_next;
    acc   <= acc_next;
    root  <= root_next;
    bitn  <= bitn_next;
  end

  always_comb begin
    state_next = state;
    dc_l_next  = dc_l;
    acc_next   = acc;
    root_next  = root;
    bitn_next  = bitn;
    sq_in      = '0;
    rsp_next   = '{done: 1'b0, h: rsp.h};
    unique case (state)
      H_IDLE: begin
        if (req.go) begin
          sq_in      = HW'(req.dr);
          acc_next   = sq;
          dc_l_next  = req.dc;
          state_next = H_DC;
        end
      end
      H_DC: begin
        sq_in      = HW'(dc_l);
        acc_next   = acc + sq;
        root_next  = '0;
        bitn_next  = BW'(HW - 1);
        state_next = H_ROOT;
      end
      H_ROOT: begin
        // floor root one bit a cycle
        sq_in = trial;
        if (sq <= acc) root_next = trial;
        if (bitn == '0) state_next = H_FIX;
        else bitn_next = bitn - 1'b1;
      end
      H_FIX: begin
        sq_in         = root;
        rsp_next.done = 1'b1;
        rsp_next.h    = (sq < acc) ? root + 1'b1 : root;
        state_next    = H_IDLE;
      end
      default: state_next = H_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/grid_astar_path_search_unit.sv]
`default_nettype none
// A* path search over a 4-connected grid held in on-chip memory.
// Commands enter on start/action/cell_row/cell_col and are taken when busy
// is low. Each command gives one result beat on the result ports, marked by
// done for one cycle; the receiver cannot stall it.
// Configuration (grid size, start, goal, expansion limit) is written through
// cfg_valid/cfg_index/cfg_data; cfg_ready is always high.
// Command flow:
//   mark obstacle: result the cycle after accept, next command at once
//   read cell: the cell is read at accept, the result is formed in S_RD
//   clear obstacles: sweeps the obstacle memory, one entry per cycle
//   run: a sweep clearing the record memory, then per expansion the limit
//     check, the open-set scan over rows*cols cells through the record memory
//     port and the pick, then up to 4 neighbors, each new heuristic computed
//     in the shared squarer unit
// After reset the block sweeps every entry of both memories with busy high;
// configuration writes are taken during that time.
module grid_astar_path_search_unit #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [5:0]  cell_row,
  input  logic [5:0]  cell_col,
  output logic        done,
  output logic [2:0]  status,
  output logic [11:0] path_cost,
  output logic        cost_valid,
  output logic        parent_valid,
  output logic [5:0]  parent_row,
  output logic [5:0]  parent_col,
  output logic        blocked,
  output logic [12:0] expansions_used,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import gasp_pkg::*;

  `include "assert_macros.svh"

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RB    = $clog2(MAX_ROWS);
  localparam int CB    = $clog2(MAX_COLS);
  localparam int FW    = ((AW > HW) ? AW : HW) + 1;

  typedef struct packed {
    logic          reached;
    logic          is_open;
    logic          closed;
    logic [AW-1:0] g;
    logic [HW-1:0] h;
    logic [RB-1:0] prow;
    logic [CB-1:0] pcol;
  } rec_t;

  function automatic logic [AW-1:0] cell_addr(logic [RB-1:0] r, logic [CB-1:0] c);
    return AW'(int'(r) * MAX_COLS + int'(c));
  endfunction

  function automatic logic [DW-1:0] absd(int a, int b);
    return DW'((a > b) ? a - b : b - a);
  endfunction

  // configuration
  logic [6:0]  grid_height, grid_width;
  logic [5:0]  start_row, start_col, goal_row, goal_col;
  logic [12:0] iteration_limit;

  // memories
  logic          obs_mem [DEPTH];
  rec_t          rec_mem [DEPTH];
  logic          obs_we, obs_wd, obs_rd;
  logic          rec_we;
  rec_t          rec_wd, rec_rd;
  logic [AW-1:0] obs_waddr, rec_waddr, raddr;

  // control and datapath
  state_t        state, state_next;
  logic [AW-1:0] ptr, ptr_next;
  logic          clr_obs, clr_obs_next, clr_rec, clr_rec_next;
  logic          clr_run, clr_run_next, clr_ack, clr_ack_next;
  logic [12:0]   exp_cnt, exp_cnt_next;
  logic          goal_reached, goal_reached_next;
  logic [AW-1:0] goal_g, goal_g_next;
  logic [5:0]    cell_r, cell_r_next, cell_c, cell_c_next;
  logic [RB-1:0] srow, srow_next, p_row, p_row_next, best_row, best_row_next;
  logic [CB-1:0] scol, scol_next, p_col, p_col_next, best_col, best_col_next;
  logic          iss_done, iss_done_next, p_vld, p_vld_next, found, found_next;
  logic [AW-1:0] p_addr, p_addr_next, best_addr, best_addr_next;
  logic [FW-1:0] best_f, best_f_next, rd_f;
  rec_t          best_rec, best_rec_next;
  logic [1:0]    k, k_next;
  logic [RB-1:0] nb_row, nb_row_next;
  logic [CB-1:0] nb_col, nb_col_next;
  logic [AW-1:0] nb_addr, nb_addr_next;
  logic          nb_closed, nb_closed_next;

  logic          fin;
  logic [2:0]    fin_status;
  logic [11:0]   fin_cost;
  logic          fin_cv, fin_pv, fin_blk;
  logic [5:0]    fin_pr, fin_pc;

  logic [RB:0]   erows;
  logic [CB:0]   ecols;
  logic          start_in, goal_in, cell_in;
  logic [AW-1:0] goal_addr, start_addr, gn;
  logic signed [RB+1:0] nr_s;
  logic signed [CB+1:0] nc_s;
  logic          nb_ok;

  heur_req_t     hreq;
  heur_rsp_t     hrsp;

  gasp_heur u_heur (
    .clk (clk),
    .rst (rst),
    .req (hreq),
    .rsp (hrsp)
  );

  assign erows = (int'(grid_height) > MAX_ROWS) ? (RB+1)'(MAX_ROWS) : (RB+1)'(grid_height);
  assign ecols = (int'(grid_width) > MAX_COLS) ? (CB+1)'(MAX_COLS) : (CB+1)'(grid_width);
  assign start_in   = (int'(start_row) < int'(erows)) && (int'(start_col) < int'(ecols));
  assign goal_in    = (int'(goal_row) < int'(erows)) && (int'(goal_col) < int'(ecols));
  assign cell_in    = (int'(cell_row) < int'(erows)) && (int'(cell_col) < int'(ecols));
  assign goal_addr  = cell_addr(RB'(goal_row), CB'(goal_col));
  assign start_addr = cell_addr(RB'(start_row), CB'(start_col));
  assign gn         = best_rec.g + 1'b1;
  assign rd_f       = FW'(rec_rd.g) + FW'(rec_rd.h);
  assign nr_s       = $signed({2'b00, best_row}) + (RB+2)'(STEP_DR[k]);
  assign nc_s       = $signed({2'b00, best_col}) + (CB+2)'(STEP_DC[k]);
  assign nb_ok      = (nr_s >= 0) && (nr_s < $signed({1'b0, erows})) &&
                      (nc_s >= 0) && (nc_s < $signed({1'b0, ecols}));

  assign busy            = (state != S_IDLE);
  assign cfg_ready       = 1'b1;
  assign expansions_used = exp_cnt;

  always_ff @(posedge clk) begin
    if (obs_we) obs_mem[obs_waddr] <= obs_wd;
    obs_rd <= obs_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_waddr] <= rec_wd;
    rec_rd <= rec_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_height     <= 7'd64;
      grid_width      <= 7'd64;
      start_row       <= '0;
      start_col       <= '0;
      goal_row        <= '0;
      goal_col        <= '0;
      iteration_limit <= 13'd4096;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEIGHT: grid_height     <= cfg_data[6:0];
        CFG_WIDTH:  grid_width      <= cfg_data[6:0];
        CFG_SROW:   start_row       <= cfg_data[5:0];
        CFG_SCOL:   start_col       <= cfg_data[5:0];
        CFG_GROW:   goal_row        <= cfg_data[5:0];
        CFG_GCOL:   goal_col        <= cfg_data[5:0];
        CFG_LIMIT:  iteration_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      ptr          <= '0;
      clr_obs      <= 1'b1;
      clr_rec      <= 1'b1;
      clr_run      <= 1'b0;
      clr_ack      <= 1'b0;
      exp_cnt      <= '0;
      goal_reached <= 1'b0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      ptr          <= ptr_next;
      clr_obs      <= clr_obs_next;
      clr_rec      <= clr_rec_next;
      clr_run      <= clr_run_next;
      clr_ack      <= clr_ack_next;
      exp_cnt      <= exp_cnt_next;
      goal_reached <= goal_reached_next;
      done         <= fin;
    end
    goal_g    <= goal_g_next;
    cell_r    <= cell_r_next;
    cell_c    <= cell_c_next;
    srow      <= srow_next;
    scol      <= scol_next;
    iss_done  <= iss_done_next;
    p_vld     <= p_vld_next;
    p_addr    <= p_addr_next;
    p_row     <= p_row_next;
    p_col     <= p_col_next;
    found     <= found_next;
    best_f    <= best_f_next;
    best_addr <= best_addr_next;
    best_row  <= best_row_next;
    best_col  <= best_col_next;
    best_rec  <= best_rec_next;
    k         <= k_next;
    nb_row    <= nb_row_next;
    nb_col    <= nb_col_next;
    nb_addr   <= nb_addr_next;
    nb_closed <= nb_closed_next;
    if (fin) begin
      status       <= fin_status;
      path_cost    <= fin_cost;
      cost_valid   <= fin_cv;
      parent_valid <= fin_pv;
      parent_row   <= fin_pr;
      parent_col   <= fin_pc;
      blocked      <= fin_blk;
    end
  end

  always_comb begin
    state_next        = state;
    ptr_next          = ptr;
    clr_obs_next      = clr_obs;
    clr_rec_next      = clr_rec;
    clr_run_next      = clr_run;
    clr_ack_next      = clr_ack;
    exp_cnt_next      = exp_cnt;
    goal_reached_next = goal_reached;
    goal_g_next       = goal_g;
    cell_r_next       = cell_r;
    cell_c_next       = cell_c;
    srow_next         = srow;
    scol_next         = scol;
    iss_done_next     = iss_done;
    p_vld_next        = p_vld;
    p_addr_next       = p_addr;
    p_row_next        = p_row;
    p_col_next        = p_col;
    found_next        = found;
    best_f_next       = best_f;
    best_addr_next    = best_addr;
    best_row_next     = best_row;
    best_col_next     = best_col;
    best_rec_next     = best_rec;
    k_next            = k;
    nb_row_next       = nb_row;
    nb_col_next       = nb_col;
    nb_addr_next      = nb_addr;
    nb_closed_next    = nb_closed;
    obs_we     = 1'b0;
    obs_wd     = 1'b0;
    obs_waddr  = ptr;
    rec_we     = 1'b0;
    rec_wd     = '0;
    rec_waddr  = ptr;
    raddr      = '0;
    hreq       = '{go: 1'b0, dr: '0, dc: '0};
    fin        = 1'b0;
    fin_status = ST_ACK;
    fin_cost   = '0;
    fin_cv     = 1'b0;
    fin_pv     = 1'b0;
    fin_pr     = '0;
    fin_pc     = '0;
    fin_blk    = 1'b0;

    unique case (state)
      S_CLR: begin
        obs_we = clr_obs;
        rec_we = clr_rec;
        ptr_next = ptr + 1'b1;
        if (int'(ptr) == DEPTH - 1) begin
          clr_obs_next = 1'b0;
          clr_rec_next = 1'b0;
          clr_run_next = 1'b0;
          clr_ack_next = 1'b0;
          if (clr_run) begin
            state_next = S_RSTART;
          end else begin
            fin        = clr_ack;
            state_next = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        raddr = cell_addr(RB'(cell_row), CB'(cell_col));
        if (start) begin
          unique case (action)
            ACT_CLEAR: begin
              ptr_next     = '0;
              clr_obs_next = 1'b1;
              clr_ack_next = 1'b1;
              state_next   = S_CLR;
            end
            ACT_MARK: begin
              // cells outside the grid are dropped
              obs_we    = cell_in;
              obs_wd    = 1'b1;
              obs_waddr = cell_addr(RB'(cell_row), CB'(cell_col));
              fin       = 1'b1;
            end
            ACT_RUN: begin
              ptr_next          = '0;
              clr_rec_next      = 1'b1;
              clr_run_next      = 1'b1;
              exp_cnt_next      = '0;
              goal_reached_next = 1'b0;
              state_next        = S_CLR;
            end
            ACT_READ: begin
              cell_r_next = cell_row;
              cell_c_next = cell_col;
              state_next  = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        fin = 1'b1;
        if ((int'(cell_r) < int'(erows)) && (int'(cell_c) < int'(ecols))) begin
          fin_blk = obs_rd;
          if (rec_rd.reached) begin
            fin_cost = 12'(rec_rd.g);
            fin_cv   = 1'b1;
            if (!(cell_r == start_row && cell_c == start_col)) begin
              fin_pv = 1'b1;
              fin_pr = 6'(rec_rd.prow);
              fin_pc = 6'(rec_rd.pcol);
            end
          end
        end
        state_next = S_IDLE;
      end
      S_RSTART: begin
        if (!start_in || !goal_in) begin
          fin        = 1'b1;
          fin_status = ST_NOPATH;
          state_next = S_IDLE;
        end else begin
          hreq.go    = 1'b1;
          hreq.dr    = absd(int'(start_row), int'(goal_row));
          hreq.dc    = absd(int'(start_col), int'(goal_col));
          state_next = S_HSTART;
        end
      end
      S_HSTART: begin
        if (hrsp.done) begin
          rec_we    = 1'b1;
          rec_waddr = start_addr;
          rec_wd    = '{reached: 1'b1, is_open: 1'b1, closed: 1'b0, g: '0, h: hrsp.h,
                        prow: '0, pcol: '0};
          if (start_addr == goal_addr) begin
            goal_reached_next = 1'b1;
            goal_g_next       = '0;
          end
          state_next = S_LIMIT;
        end
      end
      S_LIMIT: begin
        if (exp_cnt >= iteration_limit) begin
          fin        = 1'b1;
          fin_status = goal_reached ? ST_LIMIT_PATH : ST_LIMIT_NOPATH;
          fin_cost   = goal_reached ? 12'(goal_g) : '0;
          fin_cv     = goal_reached;
          state_next = S_IDLE;
        end else begin
          srow_next     = '0;
          scol_next     = '0;
          iss_done_next = 1'b0;
          p_vld_next    = 1'b0;
          found_next    = 1'b0;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        // row-major scan, strict less-than keeps the lowest index on ties
        if (!iss_done) begin
          raddr       = cell_addr(srow, scol);
          p_vld_next  = 1'b1;
          p_addr_next = cell_addr(srow, scol);
          p_row_next  = srow;
          p_col_next  = scol;
          if (int'(scol) == int'(ecols) - 1) begin
            scol_next = '0;
            if (int'(srow) == int'(erows) - 1) iss_done_next = 1'b1;
            else srow_next = srow + 1'b1;
          end else begin
            scol_next = scol + 1'b1;
          end
        end else begin
          p_vld_next = 1'b0;
        end
        if (p_vld && rec_rd.is_open && (!found || rd_f < best_f)) begin
          found_next     = 1'b1;
          best_f_next    = rd_f;
          best_addr_next = p_addr;
          best_row_next  = p_row;
          best_col_next  = p_col;
          best_rec_next  = rec_rd;
        end
        if (iss_done && !p_vld) state_next = S_PICK;
      end
      S_PICK: begin
        if (!found) begin
          fin        = 1'b1;
          fin_status = goal_reached ? ST_GOAL : ST_NOPATH;
          fin_cost   = goal_reached ? 12'(goal_g) : '0;
          fin_cv     = goal_reached;
          state_next = S_IDLE;
        end else begin
          exp_cnt_next   = exp_cnt + 1'b1;
          rec_we         = 1'b1;
          rec_waddr      = best_addr;
          rec_wd         = best_rec;
          rec_wd.is_open = 1'b0;
          rec_wd.closed  = 1'b1;
          if (best_addr == goal_addr) begin
            fin        = 1'b1;
            fin_status = ST_GOAL;
            fin_cost   = 12'(goal_g);
            fin_cv     = 1'b1;
            state_next = S_IDLE;
          end else begin
            k_next     = '0;
            state_next = S_NB;
          end
        end
      end
      S_NB: begin
        if (nb_ok) begin
          nb_row_next  = RB'(nr_s);
          nb_col_next  = CB'(nc_s);
          nb_addr_next = cell_addr(RB'(nr_s), CB'(nc_s));
          raddr        = cell_addr(RB'(nr_s), CB'(nc_s));
          state_next   = S_NBW;
        end else if (k == 2'd3) begin
          state_next = S_LIMIT;
        end else begin
          k_next = k + 1'b1;
        end
      end
      S_NBW: begin
        if (!obs_rd && (!rec_rd.reached || rec_rd.g > gn)) begin
          hreq.go        = 1'b1;
          hreq.dr        = absd(int'(nb_row), int'(goal_row));
          hreq.dc        = absd(int'(nb_col), int'(goal_col));
          nb_closed_next = rec_rd.closed;
          state_next     = S_NBH;
        end else if (k == 2'd3) begin
          state_next = S_LIMIT;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_NB;
        end
      end
      S_NBH: begin
        if (hrsp.done) begin
          rec_we    = 1'b1;
          rec_waddr = nb_addr;
          rec_wd    = '{reached: 1'b1, is_open: !nb_closed, closed: nb_closed, g: gn,
                        h: hrsp.h, prow: best_row, pcol: best_col};
          if (nb_addr == goal_addr) begin
            goal_reached_next = 1'b1;
            goal_g_next       = gn;
          end
          if (k == 2'd3) begin
            state_next = S_LIMIT;
          end else begin
            k_next     = k + 1'b1;
            state_next = S_NB;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `ASSERT_NEXT(a_run_busy, clk, rst, start && !busy && action == ACT_RUN, busy)
  `ASSERT_IMPLY(a_done_idle, clk, rst, done, !busy)
  `ASSERT_IMPLY(a_status_range, clk, rst, done, status <= ST_LIMIT_PATH)
  `ASSERT_IMPLY(a_cost_goal, clk, rst, done && status == ST_GOAL, cost_valid)

endmodule
`default_nettype wire

[verif/grid_astar_path_search_checker.sv]
`timescale 1ns / 100ps
module grid_astar_path_search_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  action,
  input  logic [5:0]  cell_row,
  input  logic [5:0]  cell_col,
  input  logic        done,
  input  logic [2:0]  status,
  input  logic [11:0] path_cost,
  input  logic        cost_valid,
  input  logic        parent_valid,
  input  logic [5:0]  parent_row,
  input  logic [5:0]  parent_col,
  input  logic        blocked,
  input  logic [12:0] expansions_used,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output int          pending,
  output int          fails
);
  import gasp_pkg::*;

  localparam int NROW = 64;
  localparam int NCOL = 64;
  localparam int NCELL = NROW * NCOL;

  typedef struct {
    logic [2:0]  status;
    logic [11:0] path_cost;
    logic        cost_valid;
    logic        parent_valid;
    logic [5:0]  parent_row;
    logic [5:0]  parent_col;
    logic        blocked;
    logic [12:0] expansions_used;
  } search_result_t;

  search_result_t expected_results[$];

  logic [6:0]  grid_h, grid_w;
  logic [5:0]  src_r, src_c, dst_r, dst_c;
  logic [12:0] exp_limit;
  bit          wall [NCELL];
  bit          reached [NCELL];
  bit          is_open [NCELL];
  bit          closed [NCELL];
  int          cost_g [NCELL];
  int          cost_h [NCELL];
  int          par_r [NCELL];
  int          par_c [NCELL];
  int          exp_count;

  function automatic int rows_used();
    return grid_h > NROW ? NROW : int'(grid_h);
  endfunction

  function automatic int cols_used();
    return grid_w > NCOL ? NCOL : int'(grid_w);
  endfunction

  function automatic bit on_grid(int r, int c);
    return r < rows_used() && c < cols_used();
  endfunction

  function automatic int dist_to_goal(int r, int c);
    int dr, dc, d, s;
    dr = r - int'(dst_r);
    dc = c - int'(dst_c);
    d = dr * dr + dc * dc;
    s = 0;
    while (s * s < d) s++;
    return s;
  endfunction

  function automatic logic [2:0] search_grid();
    int rows, cols, gi, best, bestf, br, bc, nr, nc, ni, gn;
    bit found;
    rows = rows_used();
    cols = cols_used();
    gi = int'(dst_r) * NCOL + int'(dst_c);
    for (int i = 0; i < NCELL; i++) begin
      reached[i] = 0; is_open[i] = 0; closed[i] = 0;
      cost_g[i] = 0; cost_h[i] = 0; par_r[i] = 0; par_c[i] = 0;
    end
    exp_count = 0;
    if (!on_grid(src_r, src_c) || !on_grid(dst_r, dst_c)) return ST_NOPATH;
    best = int'(src_r) * NCOL + int'(src_c);
    reached[best] = 1;
    is_open[best] = 1;
    cost_h[best] = dist_to_goal(src_r, src_c);
    forever begin
      if (exp_count >= exp_limit) return reached[gi] ? ST_LIMIT_PATH : ST_LIMIT_NOPATH;
      found = 0;
      bestf = 0;
      best = 0;
      for (int r = 0; r < rows; r++)
        for (int c = 0; c < cols; c++) begin
          ni = r * NCOL + c;
          if (is_open[ni] && (!found || cost_g[ni] + cost_h[ni] < bestf)) begin
            found = 1;
            bestf = cost_g[ni] + cost_h[ni];
            best = ni;
          end
        end
      if (!found) return reached[gi] ? ST_GOAL : ST_NOPATH;
      exp_count++;
      is_open[best] = 0;
      closed[best] = 1;
      if (best == gi) return ST_GOAL;
      br = best / NCOL;
      bc = best % NCOL;
      for (int k = 0; k < 4; k++) begin
        nr = br + STEP_DR[k];
        nc = bc + STEP_DC[k];
        gn = cost_g[best] + 1;
        if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) continue;
        ni = nr * NCOL + nc;
        if (wall[ni]) continue;
        if (!reached[ni] || cost_g[ni] > gn) begin
          reached[ni] = 1;
          cost_g[ni] = gn;
          cost_h[ni] = dist_to_goal(nr, nc);
          par_r[ni] = br;
          par_c[ni] = bc;
          is_open[ni] = !closed[ni];
        end
      end
    end
  endfunction

  function automatic search_result_t predict_command(logic [1:0] act, int r, int c);
    search_result_t res;
    int i;
    res = '{default: '0};
    case (act)
      ACT_CLEAR: begin
        for (int k = 0; k < NCELL; k++) wall[k] = 0;
      end
      ACT_MARK: begin
        if (on_grid(r, c)) wall[r * NCOL + c] = 1;
      end
      ACT_RUN: begin
        res.status = search_grid();
        if (on_grid(dst_r, dst_c)) begin
          i = int'(dst_r) * NCOL + int'(dst_c);
          if (reached[i]) begin
            res.path_cost = cost_g[i][11:0];
            res.cost_valid = 1;
          end
        end
      end
      default: begin
        if (on_grid(r, c)) begin
          i = r * NCOL + c;
          if (reached[i]) begin
            res.path_cost = cost_g[i][11:0];
            res.cost_valid = 1;
            if (!(r == src_r && c == src_c)) begin
              res.parent_valid = 1;
              res.parent_row = par_r[i][5:0];
              res.parent_col = par_c[i][5:0];
            end
          end
          res.blocked = wall[i];
        end
      end
    endcase
    res.expansions_used = exp_count[12:0];
    return res;
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endfunction

  initial begin
    grid_h = 64; grid_w = 64;
    src_r = 0; src_c = 0; dst_r = 0; dst_c = 0;
    exp_limit = 4096;
    exp_count = 0;
    fails = 0;
    pending = 0;
    for (int i = 0; i < NCELL; i++) begin
      wall[i] = 0; reached[i] = 0; is_open[i] = 0; closed[i] = 0;
      cost_g[i] = 0; cost_h[i] = 0; par_r[i] = 0; par_c[i] = 0;
    end
  end

  always @(posedge clk) begin
    search_result_t got, want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HEIGHT: grid_h = cfg_data[6:0];
          CFG_WIDTH:  grid_w = cfg_data[6:0];
          CFG_SROW:   src_r = cfg_data[5:0];
          CFG_SCOL:   src_c = cfg_data[5:0];
          CFG_GROW:   dst_r = cfg_data[5:0];
          CFG_GCOL:   dst_c = cfg_data[5:0];
          CFG_LIMIT:  exp_limit = cfg_data;
          default: ;
        endcase
      end
      // result beat first: it belongs to an earlier command
      if (done) begin
        got = '{status, path_cost, cost_valid, parent_valid, parent_row, parent_col,
                blocked, expansions_used};
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected");
          fails++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, got.status);
          check_field("path_cost", want.path_cost, got.path_cost);
          check_field("cost_valid", want.cost_valid, got.cost_valid);
          check_field("parent_valid", want.parent_valid, got.parent_valid);
          check_field("parent_row", want.parent_row, got.parent_row);
          check_field("parent_col", want.parent_col, got.parent_col);
          check_field("blocked", want.blocked, got.blocked);
          check_field("expansions_used", want.expansions_used, got.expansions_used);
        end
      end
      if (start && !busy)
        expected_results.insert(expected_results.size(),
                                predict_command(action, cell_row, cell_col));
      pending = expected_results.size();
    end
  end
endmodule

[verif/tb_grid_astar_path_search_unit.sv]
`timescale 1ns / 100ps
module tb_grid_astar_path_search_unit;
  import gasp_pkg::*;

  logic        clk, rst, start, busy, done;
  logic [1:0]  action;
  logic [5:0]  cell_row, cell_col;
  logic [2:0]  status;
  logic [11:0] path_cost;
  logic        cost_valid, parent_valid, blocked;
  logic [5:0]  parent_row, parent_col;
  logic [12:0] expansions_used;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;
  int          pending, fails;
  int          sent;
  int          h, w;

  grid_astar_path_search_unit DUT (.*);

  grid_astar_path_search_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400_000_000;
    $display("tb_grid_astar_path_search_unit NOT OK");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drops start so that no command is taken while draining
  task automatic wait_idle();
    start = 0;
    while (pending != 0 || busy) @(negedge clk);
  endtask

  // called at a falling edge with the block idle
  task automatic write_reg(logic [2:0] idx, logic [12:0] val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic set_search(int gh, int gw, int sr, int sc, int gr, int gc, int lim);
    wait_idle();
    write_reg(CFG_HEIGHT, 13'(gh));
    write_reg(CFG_WIDTH, 13'(gw));
    write_reg(CFG_SROW, 13'(sr));
    write_reg(CFG_SCOL, 13'(sc));
    write_reg(CFG_GROW, 13'(gr));
    write_reg(CFG_GCOL, 13'(gc));
    write_reg(CFG_LIMIT, 13'(lim));
  endtask

  // one command beat, then an optional gap
  task automatic issue(logic [1:0] act, int r, int c, bit with_gap);
    int gap;
    start = 1;
    action = act;
    cell_row = 6'(r);
    cell_col = 6'(c);
    do @(posedge clk); while (busy);
    @(negedge clk);
    sent++;
    gap = with_gap ? pick_gap() : 0;
    if (gap > 0) begin
      start = 0;
      action = 2'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic int in_range(int n);
    if (n == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, (n > 64 ? 64 : n) - 1);
  endfunction

  initial begin
    int mode, lim, r, n, phase_len;
    logic [1:0] act;
    start = 0; action = ACT_CLEAR; cell_row = 0; cell_col = 0;
    cfg_valid = 0; cfg_index = CFG_HEIGHT; cfg_data = 0;
    sent = 0;
    rst = 1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed part
    issue(ACT_READ, 0, 0, 0);
    issue(ACT_RUN, 0, 0, 0);
    set_search(4, 4, 0, 0, 3, 3, 8191);
    issue(ACT_MARK, 1, 1, 0);
    issue(ACT_MARK, 63, 63, 0);
    issue(ACT_MARK, 4, 0, 0);
    issue(ACT_MARK, 0, 0, 0);
    issue(ACT_RUN, 0, 0, 0);
    issue(ACT_READ, 3, 3, 0);
    issue(ACT_READ, 0, 0, 0);
    issue(ACT_READ, 1, 1, 0);
    issue(ACT_READ, 63, 63, 0);
    issue(ACT_MARK, 3, 3, 0);
    issue(ACT_RUN, 0, 0, 0);
    issue(ACT_READ, 2, 3, 0);
    set_search(4, 4, 0, 0, 3, 3, 0);
    issue(ACT_RUN, 0, 0, 0);
    set_search(0, 5, 0, 0, 0, 0, 2);
    issue(ACT_RUN, 0, 0, 0);
    issue(ACT_READ, 0, 0, 0);
    set_search(127, 127, 63, 63, 40, 63, 3);
    issue(ACT_MARK, 62, 63, 0);
    issue(ACT_RUN, 0, 0, 0);
    issue(ACT_READ, 63, 62, 0);
    issue(ACT_CLEAR, 0, 0, 0);
    set_search(1, 1, 0, 0, 0, 0, 4096);
    issue(ACT_RUN, 0, 0, 0);
    set_search(3, 3, 5, 0, 0, 0, 4096);
    issue(ACT_RUN, 0, 0, 0);

    // random phases, config changed only while idle
    while (sent < 1800) begin
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        r = $urandom_range(0, 2);
        h = (r == 0) ? 64 : (r == 1) ? $urandom_range(65, 127) : $urandom_range(9, 64);
        w = (r == 0) ? $urandom_range(65, 127) : $urandom_range(9, 64);
        lim = $urandom_range(0, 3);
      end else begin
        h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
        w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
        r = $urandom_range(0, 5);
        lim = (r == 0) ? 8191 : (r == 1) ? $urandom_range(0, 10) : $urandom_range(64, 8191);
      end
      // toggle ignored high bits of the size and start registers
      set_search(h | ($urandom_range(0, 3) == 0 ? $urandom & 13'h1f80 : 0),
                 w | ($urandom_range(0, 3) == 0 ? $urandom & 13'h1f80 : 0),
                 in_range(h) | ($urandom & 13'h1fc0),
                 in_range(w) | ($urandom & 13'h1fc0),
                 in_range(h), in_range(w), lim);
      if ($urandom_range(0, 3) == 0) issue(ACT_CLEAR, $urandom, $urandom, 1);
      phase_len = $urandom_range(20, 80);
      for (int k = 0; k < phase_len; k++) begin
        n = $urandom_range(0, 99);
        if (n < 2) act = ACT_CLEAR;
        else if (n < 38) act = ACT_MARK;
        else if (n < 46) act = ACT_RUN;
        else act = ACT_READ;
        if (act == ACT_RUN && mode == 0 && $urandom_range(0, 2) != 0) act = ACT_READ;
        issue(act, in_range(h), in_range(w), $urandom_range(0, 3) != 0);
      end
      issue(ACT_RUN, $urandom, $urandom, 1);
      for (int k = 0; k < 8; k++) issue(ACT_READ, in_range(h), in_range(w), 0);
    end

    start = 0;
    wait_idle();
    repeat (100) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb_grid_astar_path_search_unit OK");
    end else begin
      $display("tb_grid_astar_path_search_unit NOT OK");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/gasp_pkg.sv
rtl/gasp_heur.sv
rtl/grid_astar_path_search_unit.sv
verif/grid_astar_path_search_checker.sv
verif/tb_grid_astar_path_search_unit.sv
